@@ hdl/dtd_pkg.sv @@
// Shared types, constants and tables for the double to decimal digit converter.
// No dependencies; used by dtd_ctrl, dtd_dpath and double_to_decimal_digits.
package dtd_pkg;

  localparam int MaxDigits  = 16;
  localparam int ScaleSteps = 9;

  // 1e15 and 1e16 as normalized mantissa and unbiased exponent
  localparam logic [52:0]        M15 = 53'h1C6BF526340000;
  localparam logic signed [11:0] E15 = 12'sd49;
  localparam logic [52:0]        M16 = 53'h11C37937E08000;
  localparam logic signed [11:0] E16 = 12'sd53;

  // 1e16 in units of 1/8
  localparam logic [57:0] X8Limit   = 58'd80000000000000000;
  localparam logic [5:0]  AsciiZero = 6'd48;
  localparam logic [3:0]  DivTen    = 4'd10;

  typedef struct packed {
    logic       load;
    logic       norm_shift;
    logic       set_dir;
    logic       mul;
    logic [1:0] pp;
    logic       step;
    logic [3:0] idx;
    logic       limit;
    logic       add;
    logic       div_step;
    logic [2:0] div_ph;
    logic       div_rnd;
    logic       bcd_bit;
    logic       emit_adv;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic over;
    logic last;
  } stat_t;

  // 10^(2^idx) or 10^-(2^idx) as binary64 bit patterns
  function automatic logic [63:0] pow_bits(input logic up, input logic [3:0] idx);
    logic [63:0] r;
    begin
      unique case (idx)
        4'd0: r = up ? 64'h4024000000000000 : 64'h3FB999999999999A;
        4'd1: r = up ? 64'h4059000000000000 : 64'h3F847AE147AE147B;
        4'd2: r = up ? 64'h40C3880000000000 : 64'h3F1A36E2EB1C432D;
        4'd3: r = up ? 64'h4197D78400000000 : 64'h3E45798EE2308C3A;
        4'd4: r = up ? 64'h4341C37937E08000 : 64'h3C9CD2B297D889BC;
        4'd5: r = up ? 64'h4693B8B5B5056E17 : 64'h3949F623D5A8A733;
        4'd6: r = up ? 64'h4D384F03E93FF9F5 : 64'h32A50FFD44F4A73D;
        4'd7: r = up ? 64'h5A827748F9301D32 : 64'h255BBA08CF8C979D;
        4'd8: r = up ? 64'h75154FDD7F73BF3C : 64'h0AC8062864AC6F43;
        default: r = 64'h0;
      endcase
      return r;
    end
  endfunction

  // half of the last kept digit, 5*10^(15-n), in units of 1/8
  function automatic logic [57:0] half8(input logic [4:0] n);
    logic [57:0] r;
    begin
      unique case (n)
        5'd0:  r = 58'd40000000000000000;
        5'd1:  r = 58'd4000000000000000;
        5'd2:  r = 58'd400000000000000;
        5'd3:  r = 58'd40000000000000;
        5'd4:  r = 58'd4000000000000;
        5'd5:  r = 58'd400000000000;
        5'd6:  r = 58'd40000000000;
        5'd7:  r = 58'd4000000000;
        5'd8:  r = 58'd400000000;
        5'd9:  r = 58'd40000000;
        5'd10: r = 58'd4000000;
        5'd11: r = 58'd400000;
        5'd12: r = 58'd40000;
        5'd13: r = 58'd4000;
        5'd14: r = 58'd400;
        5'd15: r = 58'd40;
        5'd16: r = 58'd4;
        default: r = 58'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hdl/dtd_ctrl.sv @@
// Sequencer for the converter: walks classify, scale, round, divide, BCD and emit.
// Depends on dtd_pkg for the command and status structs.
module dtd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dtd_pkg::stat_t stat,
  output dtd_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_NORM   = 10'b0000000010,
    S_DIR    = 10'b0000000100,
    S_MUL    = 10'b0000001000,
    S_STEP   = 10'b0000010000,
    S_LIMIT  = 10'b0000100000,
    S_ADD    = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_DIVRND = 10'b0100000000,
    S_BCD    = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic       emit, emit_next;
  logic [3:0] idx, idx_next;
  logic [1:0] pp, pp_next;
  logic [5:0] cnt, cnt_next;

  assign in_ready  = (state == S_IDLE) && !emit;
  assign out_valid = emit;

  always_comb begin
    state_next = state;
    emit_next  = emit;
    idx_next   = idx;
    pp_next    = pp;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.pp     = pp;
    if (emit) begin
      if (out_ready) begin
        cmd.emit_adv = 1'b1;
        if (stat.last) emit_next = 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_NORM;
          end
        end
        S_NORM: begin
          priority if (stat.special) begin
            state_next = S_IDLE;
            emit_next  = 1'b1;
          end else if (stat.norm_done) begin
            state_next = S_DIR;
          end else begin
            cmd.norm_shift = 1'b1;
          end
        end
        S_DIR: begin
          cmd.set_dir = 1'b1;
          idx_next    = 4'(dtd_pkg::ScaleSteps - 1);
          pp_next     = 2'd0;
          state_next  = S_MUL;
        end
        S_MUL: begin
          cmd.mul = 1'b1;
          pp_next = pp + 2'd1;
          if (pp == 2'd3) state_next = S_STEP;
        end
        S_STEP: begin
          cmd.step = 1'b1;
          if (idx == 4'd0) begin
            state_next = S_LIMIT;
          end else begin
            idx_next   = idx - 4'd1;
            state_next = S_MUL;
          end
        end
        S_LIMIT: begin
          cmd.limit  = 1'b1;
          state_next = S_ADD;
        end
        S_ADD: begin
          cmd.add    = 1'b1;
          cnt_next   = 6'd0;
          state_next = stat.over ? S_DIV : S_BCD;
        end
        S_DIV: begin
          cmd.div_step = 1'b1;
          cmd.div_ph   = cnt[2:0];
          cnt_next     = cnt + 6'd1;
          if (cnt == 6'd7) state_next = S_DIVRND;
        end
        S_DIVRND: begin
          cmd.div_rnd = 1'b1;
          cnt_next    = 6'd0;
          state_next  = S_BCD;
        end
        S_BCD: begin
          cmd.bcd_bit = 1'b1;
          cnt_next    = cnt + 6'd1;
          if (cnt == 6'd53) begin
            state_next = S_IDLE;
            emit_next  = 1'b1;
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emit  <= 1'b0;
      idx   <= 4'd0;
      pp    <= 2'd0;
      cnt   <= 6'd0;
    end else begin
      state <= state_next;
      emit  <= emit_next;
      idx   <= idx_next;
      pp    <= pp_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ hdl/dtd_dpath.sv @@
// Datapath: classify, shared partial-product multiplier, rounding, divide by ten,
// binary to BCD and digit shift-out. Depends on dtd_pkg; driven by dtd_ctrl.
module dtd_dpath (
  input  logic                clk,
  input  dtd_pkg::cmd_t       cmd,
  output dtd_pkg::stat_t      stat,
  input  logic [63:0]         value_bits,
  input  logic [7:0]          digit_limit,
  input  logic [7:0]          decimal_limit,
  output logic [5:0]          digit_char,
  output logic                digit_valid,
  output logic                last_item,
  output logic                is_negative,
  output logic                is_zero,
  output logic                is_nan,
  output logic                is_infinite,
  output logic signed [9:0]   decimal_exponent,
  output logic [4:0]          digit_total
);

  logic               neg, zero_f, nan_f, inf_f, up;
  logic [52:0]        xm;
  logic signed [11:0] xe;
  logic signed [9:0]  ex;
  logic [4:0]         n, dcnt;
  logic [7:0]         dec;
  logic [105:0]       acc;
  logic [57:0]        big;
  logic [3:0]         rem;
  logic [63:0]        bcd;
  logic [57:0]        quo, dr;

  // input decode
  logic [10:0] in_expf;
  logic [51:0] in_frac;
  assign in_expf = value_bits[62:52];
  assign in_frac = value_bits[51:0];

  // multiplier constant
  logic [63:0]        cbits;
  logic [52:0]        cm;
  logic signed [11:0] ce;
  assign cbits = dtd_pkg::pow_bits(up, cmd.idx);
  assign cm    = {1'b1, cbits[51:0]};
  assign ce    = $signed({1'b0, cbits[62:52]}) - 12'sd1023;

  // one 27x27 partial product per cycle
  logic [26:0]  ap, bp;
  logic [53:0]  prod;
  logic [105:0] pp_shift;
  assign ap   = cmd.pp[1] ? {1'b0, xm[52:27]} : xm[26:0];
  assign bp   = cmd.pp[0] ? {1'b0, cm[52:27]} : cm[26:0];
  assign prod = 54'(ap * bp);
  always_comb begin
    unique case (cmd.pp)
      2'd0:    pp_shift = {52'd0, prod};
      2'd3:    pp_shift = {prod[51:0], 54'd0};
      default: pp_shift = {25'd0, prod, 27'd0};
    endcase
  end

  // round the product to 53 bits, nearest even
  logic               p_hi, p_g, p_st, p_up, take;
  logic [52:0]        p_raw, ym;
  logic [53:0]        p_sum;
  logic signed [11:0] p_e, ye;
  logic signed [9:0]  pw;
  always_comb begin
    p_hi  = acc[105];
    p_raw = p_hi ? acc[105:53] : acc[104:52];
    p_g   = p_hi ? acc[52] : acc[51];
    p_st  = p_hi ? (|acc[51:0]) : (|acc[50:0]);
    p_e   = xe + ce + (p_hi ? 12'sd1 : 12'sd0);
    p_up  = p_g & (p_st | p_raw[0]);
    p_sum = {1'b0, p_raw} + {53'd0, p_up};
    if (p_sum[53]) begin
      ym = {1'b1, 52'd0};
      ye = p_e + 12'sd1;
    end else begin
      ym = p_sum[52:0];
      ye = p_e;
    end
    if (up)
      take = (ye < dtd_pkg::E16) || (ye == dtd_pkg::E16 && ym < dtd_pkg::M16);
    else
      take = !((ye < dtd_pkg::E15) || (ye == dtd_pkg::E15 && ym < dtd_pkg::M15));
    pw = $signed(10'd1 << cmd.idx);
  end

  logic lt15;
  assign lt15 = (xe < dtd_pkg::E15) || (xe == dtd_pkg::E15 && xm < dtd_pkg::M15);

  // digit limit from the decimal limit
  logic signed [10:0] left, dl_sum;
  logic [11:0]        sh_e;
  always_comb begin
    left   = (ex > 10'sd0) ? (11'(ex) + 11'sd1) : 11'sd1;
    dl_sum = $signed({3'd0, dec}) + left;
    sh_e   = 12'(xe - dtd_pkg::E15);
  end

  // add half a digit, round the sum to 53 significant bits
  logic [57:0] s, s_mask, s_bit, s_half, s_rem, s_base, s_rnd;
  logic [2:0]  drop;
  logic        s_up;
  always_comb begin
    s = big + dtd_pkg::half8(n);
    priority if (s[56]) drop = 3'd4;
    else if (s[55])     drop = 3'd3;
    else if (s[54])     drop = 3'd2;
    else if (s[53])     drop = 3'd1;
    else                drop = 3'd0;
    s_bit  = 58'd1 << drop;
    s_mask = s_bit - 58'd1;
    s_half = s_bit >> 1;
    s_rem  = s & s_mask;
    s_base = s & ~s_mask;
    s_up   = (drop != 3'd0) &&
             ((s_rem > s_half) || (s_rem == s_half && (s & s_bit) != 58'd0));
    s_rnd  = s_base + (s_up ? s_bit : 58'd0);
  end

  // divide by ten with a shift-add reciprocal, one add a cycle; the estimate is
  // at most one low, so one compare against ten settles quotient and remainder
  logic        d_fix;
  logic [57:0] d_sub;
  assign d_fix = dr >= {54'd0, dtd_pkg::DivTen};
  assign d_sub = dr - {54'd0, dtd_pkg::DivTen};

  // quotient rounding, nearest even
  logic [4:0]  f_num;
  logic        q_up;
  logic [57:0] q_rnd;
  always_comb begin
    f_num = (big[0] ? 5'd10 : 5'd0) + {1'b0, rem};
    if (big[53]) begin
      q_up  = (f_num > 5'd10) || (f_num == 5'd10 && big[1]);
      q_rnd = {big[57:1], 1'b0} + (q_up ? 58'd2 : 58'd0);
    end else begin
      q_up  = (rem > 4'd5) || (rem == 4'd5 && big[0]);
      q_rnd = big + {57'd0, q_up};
    end
  end

  // add 3 to every BCD digit of five or more
  logic [63:0] bcd_adj;
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      bcd_adj[4*j +: 4] = (bcd[4*j +: 4] >= 4'd5) ? bcd[4*j +: 4] + 4'd3 : bcd[4*j +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= value_bits[63];
      zero_f <= (in_expf == 11'd0) && (in_frac == 52'd0);
      nan_f  <= (in_expf == 11'h7FF) && (in_frac != 52'd0);
      inf_f  <= (in_expf == 11'h7FF) && (in_frac == 52'd0);
      xm     <= {in_expf != 11'd0, in_frac};
      xe     <= (in_expf == 11'd0) ? -12'sd1022 : ($signed({1'b0, in_expf}) - 12'sd1023);
      if (in_expf == 11'h7FF)
        n <= 5'd0;
      else if (digit_limit > 8'(dtd_pkg::MaxDigits))
        n <= 5'(dtd_pkg::MaxDigits);
      else
        n <= digit_limit[4:0];
      dec  <= decimal_limit;
      ex   <= 10'sd0;
      dcnt <= 5'd0;
      bcd  <= 64'd0;
    end
    if (cmd.norm_shift) begin
      xm <= {xm[51:0], 1'b0};
      xe <= xe - 12'sd1;
    end
    if (cmd.set_dir) begin
      up <= lt15;
      ex <= 10'sd15;
    end
    if (cmd.mul) acc <= ((cmd.pp == 2'd0) ? 106'd0 : acc) + pp_shift;
    if (cmd.step && take) begin
      xm <= ym;
      xe <= ye;
      ex <= up ? ex - pw : ex + pw;
    end
    if (cmd.limit) begin
      if (dec != 8'd0 && dl_sum < $signed({6'd0, n})) n <= dl_sum[4:0];
      big <= {5'd0, xm} << sh_e[2:0];
    end
    if (cmd.add) begin
      big <= s_rnd;
      rem <= 4'd0;
    end
    if (cmd.div_step) begin
      unique case (cmd.div_ph)
        3'd0: quo <= (big >> 1) + (big >> 2);
        3'd1: quo <= quo + (quo >> 4);
        3'd2: quo <= quo + (quo >> 8);
        3'd3: quo <= quo + (quo >> 16);
        3'd4: quo <= quo + (quo >> 32);
        3'd5: quo <= quo >> 3;
        3'd6: dr  <= big - ((quo << 3) + (quo << 1));
        3'd7: begin
          big <= quo + {57'd0, d_fix};
          rem <= d_fix ? d_sub[3:0] : dr[3:0];
        end
      endcase
    end
    if (cmd.div_rnd) begin
      big <= q_rnd;
      ex  <= ex + 10'sd1;
    end
    if (cmd.bcd_bit) begin
      bcd <= {bcd_adj[62:0], big[56]};
      big <= {big[56:0], 1'b0};
    end
    if (cmd.emit_adv) begin
      bcd  <= {bcd[59:0], 4'd0};
      dcnt <= dcnt + 5'd1;
    end
  end

  assign stat.special   = zero_f | nan_f | inf_f;
  assign stat.norm_done = xm[52];
  assign stat.over      = s_rnd >= dtd_pkg::X8Limit;
  assign stat.last      = last_item;

  assign digit_valid      = (n != 5'd0);
  assign digit_char       = digit_valid ? dtd_pkg::AsciiZero + {2'd0, bcd[63:60]} : 6'd0;
  assign last_item        = (n == 5'd0) || (dcnt == n - 5'd1);
  assign is_negative      = neg;
  assign is_zero          = zero_f;
  assign is_nan           = nan_f;
  assign is_infinite      = inf_f;
  assign decimal_exponent = ex;
  assign digit_total      = n;

endmodule

@@ hdl/double_to_decimal_digits.sv @@
// Converts one IEEE binary64 value into up to sixteen ASCII decimal digits, one beat
// per digit, most significant first. Every beat carries the sign, zero, NaN and
// infinity flags, the power of ten of the first digit and the digit count; NaN,
// infinity and a zero digit count give one beat with digit_valid low. One item is
// in flight at a time. A finite value is classified, given a scale direction, scaled
// in nine scale steps on the shared 27x27 multiplier, limited by the decimal limit,
// given half a digit and converted from binary to BCD a bit at a time; the rounded
// mantissa is first divided by ten when it reaches 1e16, and a subnormal input is
// first normalized a bit at a time. Zero, NaN and infinity go from classification
// straight to output. Digits then leave at one beat per cycle while out_ready is high.
module double_to_decimal_digits (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        value_bits,
  input  logic [7:0]         digit_limit,
  input  logic [7:0]         decimal_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         digit_char,
  output logic               digit_valid,
  output logic               last_item,
  output logic               is_negative,
  output logic               is_zero,
  output logic               is_nan,
  output logic               is_infinite,
  output logic signed [9:0]  decimal_exponent,
  output logic [4:0]         digit_total
);

  dtd_pkg::cmd_t  cmd;
  dtd_pkg::stat_t stat;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtd_dpath u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .value_bits       (value_bits),
    .digit_limit      (digit_limit),
    .decimal_limit    (decimal_limit),
    .digit_char       (digit_char),
    .digit_valid      (digit_valid),
    .last_item        (last_item),
    .is_negative      (is_negative),
    .is_zero          (is_zero),
    .is_nan           (is_nan),
    .is_infinite      (is_infinite),
    .decimal_exponent (decimal_exponent),
    .digit_total      (digit_total)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while digits still pending");

  a_more_beats: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_item |=> out_valid)
    else $error("digit beats stopped before the last one");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_valid |-> digit_char >= 6'd48 && digit_char <= 6'd57)
    else $error("digit outside 0..9");

  a_special: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_nan || is_infinite) |-> !digit_valid && last_item)
    else $error("digits given for NaN or infinity");

endmodule
